// ----- sv/tst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the TCP session state tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam logic [7:0] TH_FIN = 8'h01;
    localparam logic [7:0] TH_SYN = 8'h02;
    localparam logic [7:0] TH_RST = 8'h04;
    localparam logic [7:0] TH_ACK = 8'h10;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_SYN_SENT = 3'd1;
    localparam logic [2:0] ST_SYN_RECV = 3'd2;
    localparam logic [2:0] ST_ESTAB    = 3'd3;
    localparam logic [2:0] ST_CLOSING  = 3'd4;
    localparam logic [2:0] ST_CLOSED   = 3'd5;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_NEW   = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;

    localparam logic [0:0] REG_TRACKING_ENABLE = 1'd0;

    // Per-session control entry
    typedef struct packed {
        logic [2:0] state;
        logic [3:0] marks;
        logic       est_dir;
        logic       new_rep;
        logic       close_rep;
    } t_ctl_entry;

    // Input item
    typedef struct packed {
        logic [7:0]  session_index;
        logic        session_start;
        logic        session_tracked;
        logic [7:0]  flag_bits;
        logic        direction;
        logic [15:0] packet_length;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [2:0]  conn_state;
        logic [3:0]  closing_marks;
        logic        conn_direction;
        logic [1:0]  conn_event;
        logic        state_rejected;
        logic [31:0] dir_packets;
        logic [47:0] dir_bytes;
        logic [31:0] syn_packets;
        logic [47:0] syn_bytes;
        logic [31:0] ack_packets;
        logic [47:0] ack_bytes;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic rd;      // issue memory reads
        logic wr;      // write back and register result
        logic clrpass; // write zeros at the sweep address
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;
    } t_status;

endpackage

// ----- sv/tst_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface tst_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_ctrl
// Sequencer: clearing sweep after reset, then read, update, present result.
// ----------------------------------------------------------------------------
module tst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tst_pkg::t_status  i_status,
    output tst_pkg::t_cmd     o_cmd
);
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_free;

    // Output register frees when empty or being taken
    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clrpass = 1'b1;
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                if (w_free) begin
                    o_cmd.wr    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid) else $error("result lost");
    // No write back without a pending read
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> r_state == S_UPD) else $error("write out of turn");
    // No item taken during the sweep
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready) else $error("item during sweep");
endmodule

// ----- sv/tst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_dp
// Session memories, transition logic, counters and result register.
// ----------------------------------------------------------------------------
module tst_dp #(
    parameter int SESSIONS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_enable,
    input  tst_pkg::t_in_item   i_item,
    input  tst_pkg::t_cmd       i_cmd,
    output tst_pkg::t_status    o_status,
    output tst_pkg::t_out_item  o_result
);
    localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    // Memories, one word per session; direction counters split in two
    tst_pkg::t_ctl_entry r_ctl  [SESSIONS];
    logic [79:0]         r_dir0 [SESSIONS];
    logic [79:0]         r_dir1 [SESSIONS];
    logic [79:0]         r_syn  [SESSIONS];
    logic [79:0]         r_ack  [SESSIONS];

    tst_pkg::t_ctl_entry r_rd_ctl;
    logic [79:0]         r_rd_dir0, r_rd_dir1, r_rd_syn, r_rd_ack;
    tst_pkg::t_in_item   r_item;
    logic                r_inrange;
    logic [AW-1:0]       r_sweep;
    tst_pkg::t_out_item  r_res;

    logic [AW-1:0] w_addr;
    logic          w_inrange;

    assign w_inrange = ({9'd0, i_item.session_index} < 17'(SESSIONS));
    assign w_addr    = AW'(i_item.session_index);
    assign o_status.sweep_last = (32'(r_sweep) == SESSIONS - 1);
    assign o_result  = r_res;

    // Read the entry and capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_ctl  <= r_ctl[w_addr];
            r_rd_dir0 <= r_dir0[w_addr];
            r_rd_dir1 <= r_dir1[w_addr];
            r_rd_syn  <= r_syn[w_addr];
            r_rd_ack  <= r_ack[w_addr];
            r_item    <= i_item;
            r_inrange <= w_inrange;
        end
    end

    // Advance the sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sweep <= '0;
        else if (i_cmd.clrpass) r_sweep <= r_sweep + 1'b1;
    end

    // Update logic
    tst_pkg::t_ctl_entry c;
    logic [79:0] dcnt, scnt, acnt;
    logic [1:0]  ev;
    logic        rej, rst, fin, syn, ack, act;

    always_comb begin
        c    = r_rd_ctl;
        dcnt = r_item.direction ? r_rd_dir1 : r_rd_dir0;
        scnt = r_rd_syn;
        acnt = r_rd_ack;
        if (r_item.session_start) begin
            c = '0; dcnt = '0; scnt = '0; acnt = '0;
        end
        rst = r_item.flag_bits[2];
        fin = r_item.flag_bits[0];
        syn = r_item.flag_bits[1];
        ack = r_item.flag_bits[4];
        ev  = tst_pkg::EV_NONE;
        rej = 1'b0;
        act = i_enable && r_item.session_tracked;
        if (act) begin
            case (c.state)
                tst_pkg::ST_NONE: begin
                    if (rst || fin) rej = 1'b1;
                    else if (syn && ack) c.state = tst_pkg::ST_SYN_RECV;
                    else if (syn) c.state = tst_pkg::ST_SYN_SENT;
                    else if (ack) begin
                        c.state = tst_pkg::ST_ESTAB; c.est_dir = r_item.direction;
                    end
                end
                tst_pkg::ST_SYN_SENT: begin
                    if (rst) c.state = tst_pkg::ST_CLOSED;
                    else if (fin) c.state = c.state;
                    else if (syn && ack) c.state = tst_pkg::ST_SYN_RECV;
                    else if (syn) c.state = c.state;
                    else if (ack) begin
                        c.state = tst_pkg::ST_ESTAB; c.est_dir = r_item.direction;
                        c.new_rep = 1'b0; c.close_rep = 1'b0;
                    end
                end
                tst_pkg::ST_SYN_RECV: begin
                    if (rst) c.state = tst_pkg::ST_CLOSED;
                    else if (fin) begin
                        c.state = tst_pkg::ST_CLOSING; c.marks = 4'h1;
                    end else if (syn) c.state = c.state;
                    else if (ack) begin
                        c.state = tst_pkg::ST_ESTAB; c.est_dir = r_item.direction;
                        c.new_rep = 1'b0; c.close_rep = 1'b0;
                    end
                end
                tst_pkg::ST_ESTAB: begin
                    if (rst) c.state = tst_pkg::ST_CLOSED;
                    else if (fin) begin
                        c.state = tst_pkg::ST_CLOSING; c.marks = 4'h1;
                    end
                end
                tst_pkg::ST_CLOSING: begin
                    if (rst) c.state = tst_pkg::ST_CLOSED;
                    else if (fin) c.marks = c.marks | 4'h2;
                    else if (ack) c.marks = c.marks | (c.marks[2] ? 4'h8 : 4'h4);
                    else if (syn) c.state = tst_pkg::ST_SYN_SENT;
                end
                tst_pkg::ST_CLOSED: begin
                    if (syn && ack) c.state = tst_pkg::ST_SYN_RECV;
                    else if (syn) c.state = tst_pkg::ST_SYN_SENT;
                end
                default: c.state = c.state;
            endcase
            if (!c.new_rep && c.state == tst_pkg::ST_ESTAB) begin
                ev = tst_pkg::EV_NEW; c.new_rep = 1'b1;
            end else if (c.state == tst_pkg::ST_CLOSING && c.marks == 4'hF
                         && !c.close_rep) begin
                ev = tst_pkg::EV_CLOSE; c.state = tst_pkg::ST_CLOSED; c.close_rep = 1'b1;
            end
            dcnt = {dcnt[79:48] + 32'd1, dcnt[47:0] + {32'd0, r_item.packet_length}};
            if (!r_item.direction && r_item.flag_bits == tst_pkg::TH_SYN)
                scnt = {scnt[79:48] + 32'd1, scnt[47:0] + {32'd0, r_item.packet_length}};
            else if (!r_item.direction && (r_item.flag_bits & tst_pkg::TH_ACK) != 8'd0)
                acnt = {acnt[79:48] + 32'd1, acnt[47:0] + {32'd0, r_item.packet_length}};
        end
    end

    // Write back, or clear during the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.clrpass) begin
            r_ctl[r_sweep]  <= '0;
            r_dir0[r_sweep] <= '0;
            r_dir1[r_sweep] <= '0;
            r_syn[r_sweep]  <= '0;
            r_ack[r_sweep]  <= '0;
        end else if (i_cmd.wr && r_inrange) begin
            r_ctl[AW'(r_item.session_index)] <= c;
            if (r_item.session_start || (act && !r_item.direction))
                r_dir0[AW'(r_item.session_index)] <=
                    r_item.direction ? (r_item.session_start ? 80'd0 : r_rd_dir0) : dcnt;
            if (r_item.session_start || (act && r_item.direction))
                r_dir1[AW'(r_item.session_index)] <=
                    r_item.direction ? dcnt : (r_item.session_start ? 80'd0 : r_rd_dir1);
            r_syn[AW'(r_item.session_index)] <= scnt;
            r_ack[AW'(r_item.session_index)] <= acnt;
        end
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            if (r_inrange)
                r_res <= '{c.state, c.marks, c.est_dir, ev, rej, dcnt[79:48], dcnt[47:0],
                           scnt[79:48], scnt[47:0], acnt[79:48], acnt[47:0]};
            else
                r_res <= '0;
        end
    end
endmodule

// ----- sv/tcp_session_state_tracker_top.sv -----
`timescale 1ns / 1ps
// An accepted item is read from memory, then updated and registered as the result; a waiting result holds the update.
// A new item is taken only after the previous one is read and written back.
// The output register lets the next item enter while a result waits.
// Reset: synchronous, active low; a clearing sweep over all SESSIONS entries follows,
// during which no item is accepted (configuration writes are taken).
// ----------------------------------------------------------------------------
// tcp_session_state_tracker_top
// Per-session TCP connection tracker with APB configuration.
// ----------------------------------------------------------------------------
module tcp_session_state_tracker_top #(
    parameter int SESSIONS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tst_if.sink         in_if,
    tst_if.source       out_if,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic             r_enable;
    tst_pkg::t_cmd    w_cmd;
    tst_pkg::t_status w_status;

    assign pready = 1'b1;
    // Write the enable register at address zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_enable <= 1'b0;
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0
                 && 1'(paddr[1:0] >> 2) == tst_pkg::REG_TRACKING_ENABLE)
            r_enable <= pwdata[0];
    end
    assign prdata = (paddr == 2'd0) ? {31'd0, r_enable} : 32'd0;

    tst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .o_in_ready(in_if.ready),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    tst_dp #(.SESSIONS(SESSIONS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_enable(r_enable),
        .i_item(in_if.data), .i_cmd(w_cmd), .o_status(w_status),
        .o_result(out_if.data)
    );
endmodule
